FILE: rtl/obb_pkg.sv
// Shared constants and register codes for the oriented-box overlap tester.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package obb_pkg;

  // Default component widths: Q16.4 coordinates and Q1.14 axes.
  localparam int COORD_WIDTH_DEF = 20;
  localparam int AXIS_WIDTH_DEF  = 16;

  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_A_CENTER  = 3'd0,
    REG_A_AXIS_U  = 3'd1,
    REG_A_AXIS_V  = 3'd2,
    REG_A_AXIS_W  = 3'd3,
    REG_A_EXTENTS = 3'd4
  } obb_reg_t;

endpackage

`default_nettype wire

FILE: rtl/obb_obb_overlap_test.sv
// Oriented-box overlap tester: fifteen-axis separating-axis test, fully pipelined.
// Depends on obb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// This block tests a stream of boxes B against one box A that is held in
// configuration registers, and answers one overlap bit for every input word.
// Box A is written through the plain write port (index 0 center, 1 to 3 the
// u, v and w axes, 4 the half extents); write it only while the pipeline is
// empty. Each test checks A's three axes, B's three axes and the nine cross
// products with a strict greater-than, so boxes that just touch overlap.
// All arithmetic is exact: nothing is rounded or saturated, and axes are
// used as given, without normalization. The pipeline has seven register
// stages. The first is loaded at the edge that accepts a box, and a new
// box can enter every cycle unless a stalled output backs up to it. The depth is set by
// the multiplier chain: the center offset, the axis products, their
// dot-product sums, the radius and projection products (the wide projection
// products are split in two halves), the sums of those, the cross-axis
// distances and finally the magnitude compare. Each stage holds its own
// valid bit and moves whenever the stage after it is free, so a stalled
// output only stops the stages that are full behind it, and a finished
// result in the output register does not keep new words from entering
// empty stages.
module obb_obb_overlap_test #(
  parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_WIDTH  = obb_pkg::AXIS_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration write port.
  input  wire logic                                 cfg_we,
  input  wire logic [obb_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [((COORD_WIDTH > AXIS_WIDTH) ? 3*COORD_WIDTH : 3*AXIS_WIDTH)-1:0]
                                                    cfg_data,
  // Input words: one box B each.
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [3*COORD_WIDTH-1:0]             b_center,
  input  wire logic [3*AXIS_WIDTH-1:0]              b_axis_u,
  input  wire logic [3*AXIS_WIDTH-1:0]              b_axis_v,
  input  wire logic [3*AXIS_WIDTH-1:0]              b_axis_w,
  input  wire logic [3*COORD_WIDTH-1:0]             b_extents,
  // Result words.
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      overlap
);
  import obb_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = AXIS_WIDTH;
  localparam int F    = AW - 2;              // axis fraction bits
  localparam int DW   = CW + 1;              // center difference
  localparam int PW   = DW + AW;             // offset times axis component
  localparam int TW   = PW + 2;              // projected offset t
  localparam int RW   = 2*AW + 2;            // rotation entry r
  localparam int TL   = (TW + 1) / 2;        // low half of t
  localparam int TH   = TW - TL;             // high half of t
  localparam int EW   = CW + RW;             // extent times |r|
  localparam int LW   = TL + 1 + RW;         // low half product
  localparam int HW   = TH + RW;             // high half product
  localparam int CMPW = CW + DW + 3*AW + 8;  // common compare width

  // Box A registers.
  logic [3*CW-1:0] a_center;
  logic [3*AW-1:0] a_axis_u;
  logic [3*AW-1:0] a_axis_v;
  logic [3*AW-1:0] a_axis_w;
  logic [3*CW-1:0] a_extents;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_center  <= '0;
      a_axis_u  <= '0;
      a_axis_v  <= '0;
      a_axis_w  <= '0;
      a_extents <= '0;
    end else if (cfg_we) begin
      case (obb_reg_t'(cfg_index))
        REG_A_CENTER:  a_center  <= cfg_data[3*CW-1:0];
        REG_A_AXIS_U:  a_axis_u  <= cfg_data[3*AW-1:0];
        REG_A_AXIS_V:  a_axis_v  <= cfg_data[3*AW-1:0];
        REG_A_AXIS_W:  a_axis_w  <= cfg_data[3*AW-1:0];
        REG_A_EXTENTS: a_extents <= cfg_data[3*CW-1:0];
        default: ;
      endcase
    end
  end

  // Unpacked box A.
  logic signed [AW-1:0] au [3][3];
  logic        [CW-1:0] ea [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      au[0][k] = a_axis_u[k*AW +: AW];
      au[1][k] = a_axis_v[k*AW +: AW];
      au[2][k] = a_axis_w[k*AW +: AW];
      ea[k]    = a_extents[k*CW +: CW];
    end
  end

  // Stage valid bits and advance enables.
  logic [7:1] v;
  logic [7:1] en;
  assign en[7] = !v[7] || out_ready;
  always_comb begin
    for (int s = 6; s >= 1; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end
  assign in_ready  = en[1];
  assign out_valid = v[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int s = 2; s <= 7; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // Stage 1: center offset, B axes and extents.
  logic signed [DW-1:0] d1  [3];
  logic signed [AW-1:0] bu1 [3][3];
  logic        [CW-1:0] eb1 [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        d1[k]     <= DW'($signed(b_center[k*CW +: CW])) - DW'($signed(a_center[k*CW +: CW]));
        bu1[0][k] <= b_axis_u[k*AW +: AW];
        bu1[1][k] <= b_axis_v[k*AW +: AW];
        bu1[2][k] <= b_axis_w[k*AW +: AW];
        eb1[k]    <= b_extents[k*CW +: CW];
      end
    end
  end

  // Stage 2: elementwise products for t = A^T d and r = A^T B.
  logic signed [PW-1:0]   pd2 [3][3];
  logic signed [2*AW-1:0] pr2 [3][3][3];
  logic        [CW-1:0]   eb2 [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        eb2[i] <= eb1[i];
        for (int k = 0; k < 3; k++) begin
          pd2[i][k] <= PW'(d1[k]) * PW'(au[i][k]);
          for (int j = 0; j < 3; j++) begin
            pr2[i][j][k] <= (2*AW)'(au[i][k]) * (2*AW)'(bu1[j][k]);
          end
        end
      end
    end
  end

  // Stage 3: dot-product sums and magnitudes.
  logic signed [TW-1:0] t3  [3];
  logic signed [RW-1:0] r3  [3][3];
  logic        [RW-1:0] ar3 [3][3];
  logic        [CW-1:0] eb3 [3];
  logic signed [RW-1:0] r_sum [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r_sum[i][j] = RW'(pr2[i][j][0]) + RW'(pr2[i][j][1]) + RW'(pr2[i][j][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        eb3[i] <= eb2[i];
        t3[i]  <= TW'(pd2[i][0]) + TW'(pd2[i][1]) + TW'(pd2[i][2]);
        for (int j = 0; j < 3; j++) begin
          r3[i][j]  <= r_sum[i][j];
          ar3[i][j] <= r_sum[i][j][RW-1] ? RW'(-r_sum[i][j]) : RW'(r_sum[i][j]);
        end
      end
    end
  end

  // Stage 4: radius products and split projection products.
  // mea4[x][y][j] = ea[x] * |r[y][j]|, meb4[x][i][y] = eb[x] * |r[i][y]|,
  // and t[x] * r[y][j] is formed from the two halves of t[x].
  logic        [EW-1:0] mea4 [3][3][3];
  logic        [EW-1:0] meb4 [3][3][3];
  logic signed [LW-1:0] tlo4 [3][3][3];
  logic signed [HW-1:0] thi4 [3][3][3];
  logic signed [TW-1:0] t4   [3];
  logic        [CW-1:0] eb4  [3];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int x = 0; x < 3; x++) begin
        t4[x]  <= t3[x];
        eb4[x] <= eb3[x];
        for (int y = 0; y < 3; y++) begin
          for (int j = 0; j < 3; j++) begin
            mea4[x][y][j] <= EW'(ea[x]) * EW'(ar3[y][j]);
            meb4[x][y][j] <= EW'(eb3[x]) * EW'(ar3[y][j]);
            tlo4[x][y][j] <= LW'($signed({1'b0, t3[x][TL-1:0]})) * LW'(r3[y][j]);
            thi4[x][y][j] <= HW'($signed(t3[x][TW-1:TL])) * HW'(r3[y][j]);
          end
        end
      end
    end
  end

  // Stage 5: full projection products, radii and A-axis distances.
  logic signed [CMPW-1:0] tr5   [3][3][3];
  logic signed [CMPW-1:0] rhsa5 [3];
  logic signed [CMPW-1:0] lhsa5 [3];
  logic signed [CMPW-1:0] rhsb5 [3];
  logic signed [CMPW-1:0] rad5  [3][3];

  logic signed [CMPW-1:0] tr_n   [3][3][3];
  logic signed [CMPW-1:0] rhsa_n [3];
  logic signed [CMPW-1:0] lhsa_n [3];
  logic signed [CMPW-1:0] rhsb_n [3];
  logic signed [CMPW-1:0] rad_n  [3][3];
  logic signed [CMPW-1:0] tw_ext;
  logic signed [CMPW-1:0] ra_sum;
  int i1, i2, j1, j2;

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        for (int j = 0; j < 3; j++) begin
          tr_n[x][y][j] = (CMPW'(thi4[x][y][j]) <<< TL) + CMPW'(tlo4[x][y][j]);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      tw_ext    = CMPW'(t4[i]);
      lhsa_n[i] = (tw_ext[CMPW-1] ? -tw_ext : tw_ext) <<< F;
      rhsa_n[i] = (CMPW'(ea[i]) <<< (2*F)) + CMPW'(meb4[0][i][0])
                + CMPW'(meb4[1][i][1]) + CMPW'(meb4[2][i][2]);
      ra_sum    = CMPW'(mea4[0][0][i]) + CMPW'(mea4[1][1][i]) + CMPW'(mea4[2][2][i]);
      rhsb_n[i] = (ra_sum <<< F) + (CMPW'(eb4[i]) <<< (3*F));
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i == 2) ? 0 : i + 1;
      i2 = (i == 0) ? 2 : i - 1;
      for (int j = 0; j < 3; j++) begin
        j1 = (j == 2) ? 0 : j + 1;
        j2 = (j == 0) ? 2 : j - 1;
        rad_n[i][j] = (CMPW'(mea4[i1][i2][j]) + CMPW'(mea4[i2][i1][j])
                     + CMPW'(meb4[j1][i][j2]) + CMPW'(meb4[j2][i][j1])) <<< F;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tr5   <= tr_n;
      rhsa5 <= rhsa_n;
      lhsa5 <= lhsa_n;
      rhsb5 <= rhsb_n;
      rad5  <= rad_n;
    end
  end

  // Stage 6: B-axis projections and cross-axis distances, as magnitudes.
  logic signed [CMPW-1:0] proj6 [3];
  logic signed [CMPW-1:0] dist6 [3][3];
  logic signed [CMPW-1:0] rhsa6 [3];
  logic signed [CMPW-1:0] lhsa6 [3];
  logic signed [CMPW-1:0] rhsb6 [3];
  logic signed [CMPW-1:0] rad6  [3][3];

  logic signed [CMPW-1:0] proj_n [3];
  logic signed [CMPW-1:0] dist_n [3][3];
  int k1, k2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      proj_n[j] = tr5[0][0][j] + tr5[1][1][j] + tr5[2][2][j];
    end
    for (int i = 0; i < 3; i++) begin
      k1 = (i == 2) ? 0 : i + 1;
      k2 = (i == 0) ? 2 : i - 1;
      for (int j = 0; j < 3; j++) begin
        dist_n[i][j] = tr5[k2][k1][j] - tr5[k1][k2][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 3; j++) begin
        proj6[j] <= proj_n[j][CMPW-1] ? -proj_n[j] : proj_n[j];
        for (int i = 0; i < 3; i++) begin
          dist6[i][j] <= dist_n[i][j][CMPW-1] ? -dist_n[i][j] : dist_n[i][j];
        end
      end
      rhsa6 <= rhsa5;
      lhsa6 <= lhsa5;
      rhsb6 <= rhsb5;
      rad6  <= rad5;
    end
  end

  // Stage 7: fifteen strict compares, folded into the output register.
  logic sep_any;
  always_comb begin
    sep_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (lhsa6[i] > rhsa6[i]) sep_any = 1'b1;
      if (proj6[i] > rhsb6[i]) sep_any = 1'b1;
      for (int j = 0; j < 3; j++) begin
        if (dist6[i][j] > rad6[i][j]) sep_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      overlap <= !sep_any;
    end
  end

  // A word accepted at the input lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[1])
    else $error("accepted word did not enter stage 1");

  // A full stage that cannot advance keeps its word.
  assert property (@(posedge clk) disable iff (rst)
    v[6] && !en[6] |=> v[6])
    else $error("stalled stage 6 lost its word");

  // A full stage whose successor is free hands its word on.
  assert property (@(posedge clk) disable iff (rst)
    v[6] && en[7] |=> v[7])
    else $error("stage 6 word did not reach the output");

endmodule

`default_nettype wire
